// ===== src/sc2a_pkg.sv =====
// ----------------------------------------------------------------------------
// sc2a_pkg: shared types, constants and key tables
// Command format between the classifier front end and the ring back end,
// scancode constants and the US plain and shifted translation tables.
// ----------------------------------------------------------------------------
package sc2a_pkg;

    localparam int RING_DEPTH_DEF = 128;
    localparam int CMD_FIFO_DEPTH = 4;

    localparam int PID_W   = 17;
    localparam int CHAR_W  = 8;
    localparam int SCAN_W  = 8;
    localparam int CODE_W  = 7;
    localparam int TGT_W   = 16;

    localparam logic [CODE_W-1:0] KEY_CTRL   = 7'h1D;
    localparam logic [CODE_W-1:0] KEY_LSHIFT = 7'h2A;
    localparam logic [CODE_W-1:0] KEY_RSHIFT = 7'h36;
    localparam logic [CHAR_W-1:0] CHAR_ETX   = 8'h03;
    localparam logic [CHAR_W-1:0] CHAR_LC_C  = 8'h63;

    localparam logic OP_SCAN = 1'b0;
    localparam logic OP_READ = 1'b1;

    typedef enum logic [1:0] {
        CMD_NONE = 2'd0,
        CMD_READ = 2'd1,
        CMD_PUSH = 2'd2,
        CMD_ETX  = 2'd3
    } t_cmd_kind;

    typedef struct packed {
        t_cmd_kind         kind;
        logic [CHAR_W-1:0] ch;
    } t_cmd;

    function automatic logic [CHAR_W-1:0] plain_map(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'd1:  c = 8'h1B;  7'd2:  c = 8'h31;  7'd3:  c = 8'h32;  7'd4:  c = 8'h33;
            7'd5:  c = 8'h34;  7'd6:  c = 8'h35;  7'd7:  c = 8'h36;  7'd8:  c = 8'h37;
            7'd9:  c = 8'h38;  7'd10: c = 8'h39;  7'd11: c = 8'h30;  7'd12: c = 8'h2D;
            7'd13: c = 8'h3D;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h71;
            7'd17: c = 8'h77;  7'd18: c = 8'h65;  7'd19: c = 8'h72;  7'd20: c = 8'h74;
            7'd21: c = 8'h79;  7'd22: c = 8'h75;  7'd23: c = 8'h69;  7'd24: c = 8'h6F;
            7'd25: c = 8'h70;  7'd26: c = 8'h5B;  7'd27: c = 8'h5D;  7'd28: c = 8'h0A;
            7'd30: c = 8'h61;  7'd31: c = 8'h73;  7'd32: c = 8'h64;  7'd33: c = 8'h66;
            7'd34: c = 8'h67;  7'd35: c = 8'h68;  7'd36: c = 8'h6A;  7'd37: c = 8'h6B;
            7'd38: c = 8'h6C;  7'd39: c = 8'h3B;  7'd40: c = 8'h27;  7'd41: c = 8'h60;
            7'd43: c = 8'h5C;  7'd44: c = 8'h7A;  7'd45: c = 8'h78;  7'd46: c = 8'h63;
            7'd47: c = 8'h76;  7'd48: c = 8'h62;  7'd49: c = 8'h6E;  7'd50: c = 8'h6D;
            7'd51: c = 8'h2C;  7'd52: c = 8'h2E;  7'd53: c = 8'h2F;  7'd55: c = 8'h2A;
            7'd57: c = 8'h20;  7'd74: c = 8'h2D;  7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

    function automatic logic [CHAR_W-1:0] shift_map(input logic [CODE_W-1:0] code);
        logic [CHAR_W-1:0] c;
        case (code)
            7'd1:  c = 8'h1B;  7'd2:  c = 8'h21;  7'd3:  c = 8'h40;  7'd4:  c = 8'h23;
            7'd5:  c = 8'h24;  7'd6:  c = 8'h25;  7'd7:  c = 8'h5E;  7'd8:  c = 8'h26;
            7'd9:  c = 8'h2A;  7'd10: c = 8'h28;  7'd11: c = 8'h29;  7'd12: c = 8'h5F;
            7'd13: c = 8'h2B;  7'd14: c = 8'h08;  7'd15: c = 8'h09;  7'd16: c = 8'h51;
            7'd17: c = 8'h57;  7'd18: c = 8'h45;  7'd19: c = 8'h52;  7'd20: c = 8'h54;
            7'd21: c = 8'h59;  7'd22: c = 8'h55;  7'd23: c = 8'h49;  7'd24: c = 8'h4F;
            7'd25: c = 8'h50;  7'd26: c = 8'h7B;  7'd27: c = 8'h7D;  7'd28: c = 8'h0A;
            7'd30: c = 8'h41;  7'd31: c = 8'h53;  7'd32: c = 8'h44;  7'd33: c = 8'h46;
            7'd34: c = 8'h47;  7'd35: c = 8'h48;  7'd36: c = 8'h4A;  7'd37: c = 8'h4B;
            7'd38: c = 8'h4C;  7'd39: c = 8'h3A;  7'd40: c = 8'h22;  7'd41: c = 8'h7E;
            7'd43: c = 8'h7C;  7'd44: c = 8'h5A;  7'd45: c = 8'h58;  7'd46: c = 8'h43;
            7'd47: c = 8'h56;  7'd48: c = 8'h42;  7'd49: c = 8'h4E;  7'd50: c = 8'h4D;
            7'd51: c = 8'h3C;  7'd52: c = 8'h3E;  7'd53: c = 8'h3F;  7'd55: c = 8'h2A;
            7'd57: c = 8'h20;  7'd74: c = 8'h2D;  7'd78: c = 8'h2B;
            default: c = 8'h00;
        endcase
        return c;
    endfunction

endpackage

// ===== src/sc2a_front.sv =====
// ----------------------------------------------------------------------------
// sc2a_front: item classifier
// Tracks the ctrl and shift modifiers, translates key presses and turns each
// accepted item into one command for the ring back end.
// ----------------------------------------------------------------------------
module sc2a_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    input  logic                         i_operation,
    input  logic [sc2a_pkg::SCAN_W-1:0]  i_scan_byte,
    input  logic                         i_full,
    output logic                         o_stall,
    output logic                         o_push,
    output sc2a_pkg::t_cmd               o_cmd
);

    logic                          r_ctrl_down;
    logic                          n_ctrl_down;
    logic                          r_shift_down;
    logic                          n_shift_down;
    logic [sc2a_pkg::CODE_W-1:0]   code;
    logic [sc2a_pkg::CHAR_W-1:0]   plain_ch;
    logic [sc2a_pkg::CHAR_W-1:0]   shift_ch;
    logic [sc2a_pkg::CHAR_W-1:0]   ch;
    logic                          is_shift_key;

    assign o_stall = i_full;
    assign o_push  = i_valid && !i_full;

    assign code         = i_scan_byte[sc2a_pkg::CODE_W-1:0];
    assign plain_ch     = sc2a_pkg::plain_map(code);
    assign shift_ch     = sc2a_pkg::shift_map(code);
    assign ch           = r_shift_down ? shift_ch : plain_ch;
    assign is_shift_key = (code == sc2a_pkg::KEY_LSHIFT) || (code == sc2a_pkg::KEY_RSHIFT);

    always_comb begin
        n_ctrl_down  = r_ctrl_down;
        n_shift_down = r_shift_down;
        o_cmd.kind   = sc2a_pkg::CMD_NONE;
        o_cmd.ch     = '0;
        if (i_operation == sc2a_pkg::OP_READ) begin
            o_cmd.kind = sc2a_pkg::CMD_READ;
        end else if (i_scan_byte[sc2a_pkg::SCAN_W-1]) begin
            // release: only modifiers matter
            if (code == sc2a_pkg::KEY_CTRL) begin
                n_ctrl_down = 1'b0;
            end else if (is_shift_key) begin
                n_shift_down = 1'b0;
            end
        end else if (code == sc2a_pkg::KEY_CTRL) begin
            n_ctrl_down = 1'b1;
        end else if (is_shift_key) begin
            n_shift_down = 1'b1;
        end else if (r_ctrl_down && plain_ch == sc2a_pkg::CHAR_LC_C) begin
            o_cmd.kind = sc2a_pkg::CMD_ETX;
            o_cmd.ch   = sc2a_pkg::CHAR_ETX;
        end else if (ch != '0) begin
            o_cmd.kind = sc2a_pkg::CMD_PUSH;
            o_cmd.ch   = ch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_down  <= 1'b0;
            r_shift_down <= 1'b0;
        end else if (o_push) begin
            r_ctrl_down  <= n_ctrl_down;
            r_shift_down <= n_shift_down;
        end
    end

endmodule

// ===== src/sc2a_cmd_fifo.sv =====
// ----------------------------------------------------------------------------
// sc2a_cmd_fifo: command queue
// Small register queue that decouples the classifier from the ring back end.
// ----------------------------------------------------------------------------
module sc2a_cmd_fifo (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  sc2a_pkg::t_cmd  i_cmd,
    input  logic            i_pop,
    output logic            o_full,
    output logic            o_not_empty,
    output sc2a_pkg::t_cmd  o_cmd
);

    localparam int DEPTH = sc2a_pkg::CMD_FIFO_DEPTH;
    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sc2a_pkg::t_cmd    r_mem [DEPTH];
    logic [PTR_W-1:0]  r_wp;
    logic [PTR_W-1:0]  r_rp;
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  n_cnt;

    assign o_full      = (r_cnt == CNT_W'(DEPTH));
    assign o_not_empty = (r_cnt != '0);
    assign o_cmd       = r_mem[r_rp];

    always_comb begin
        n_cnt = r_cnt;
        if (i_push && !i_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (!i_push && i_pop) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

endmodule

// ===== src/sc2a_ring.sv =====
// ----------------------------------------------------------------------------
// sc2a_ring: character ring and result register
// Executes one command per cycle, while the result register is not stalled,
// against the character ring and holds the result in an output register until the consumer takes it.
// ----------------------------------------------------------------------------
module sc2a_ring #(
    parameter int RING_DEPTH = sc2a_pkg::RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cmd_valid,
    input  sc2a_pkg::t_cmd               i_cmd,
    input  logic [sc2a_pkg::PID_W-1:0]   i_fg_pid,
    input  logic                         i_out_stall,
    output logic                         o_pop,
    output logic                         o_out_valid,
    output logic                         o_read_valid,
    output logic [sc2a_pkg::CHAR_W-1:0]  o_read_char,
    output logic                         o_echo_valid,
    output logic [sc2a_pkg::CHAR_W-1:0]  o_echo_char,
    output logic                         o_wake_reader,
    output logic                         o_dropped,
    output logic                         o_interrupt_valid,
    output logic [sc2a_pkg::TGT_W-1:0]   o_interrupt_target,
    output logic                         o_ctrl_c_seen
);

    localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(RING_DEPTH - 1);

    logic [sc2a_pkg::CHAR_W-1:0]  r_ring [RING_DEPTH];
    logic [PTR_W-1:0]             r_rp;
    logic [PTR_W-1:0]             r_wp;
    logic [PTR_W-1:0]             wp_next;
    logic [PTR_W-1:0]             rp_next;
    logic                         advance;
    logic                         empty;
    logic                         full;
    logic                         is_read;
    logic                         is_push;
    logic                         is_etx;
    logic                         do_pop;
    logic                         do_write;
    logic                         pid_set;

    logic                         r_out_valid;
    logic                         r_read_valid;
    logic [sc2a_pkg::CHAR_W-1:0]  r_rd_q;
    logic                         r_echo_valid;
    logic [sc2a_pkg::CHAR_W-1:0]  r_echo_char;
    logic                         r_wake;
    logic                         r_dropped;
    logic                         r_int_valid;
    logic [sc2a_pkg::TGT_W-1:0]   r_int_target;
    logic                         r_ctrl_c;

    // the result register moves whenever it is empty or being taken
    assign advance = !r_out_valid || !i_out_stall;
    assign o_pop   = advance && i_cmd_valid;

    assign wp_next = (r_wp == PTR_LAST) ? '0 : r_wp + 1'b1;
    assign rp_next = (r_rp == PTR_LAST) ? '0 : r_rp + 1'b1;
    assign empty   = (r_rp == r_wp);
    assign full    = (wp_next == r_rp);   // one slot always stays free

    assign is_read  = (i_cmd.kind == sc2a_pkg::CMD_READ);
    assign is_push  = (i_cmd.kind == sc2a_pkg::CMD_PUSH);
    assign is_etx   = (i_cmd.kind == sc2a_pkg::CMD_ETX);
    assign do_pop   = o_pop && is_read && !empty;
    assign do_write = o_pop && (is_push || is_etx) && !full;
    assign pid_set  = !i_fg_pid[sc2a_pkg::PID_W-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rp <= '0;
            r_wp <= '0;
        end else begin
            if (do_pop) begin
                r_rp <= rp_next;
            end
            if (do_write) begin
                r_wp <= wp_next;
            end
        end
    end

    // ring memory: a pop never addresses the slot written in the same cycle
    always_ff @(posedge i_clk) begin
        if (do_write) begin
            r_ring[r_wp] <= i_cmd.ch;
        end
        if (o_pop) begin
            r_rd_q <= r_ring[r_rp];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= i_cmd_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_read_valid <= is_read && !empty;
            r_echo_valid <= is_push;
            r_echo_char  <= is_push ? i_cmd.ch : '0;
            r_wake       <= is_push || is_etx;
            r_dropped    <= (is_push || is_etx) && full;
            r_int_valid  <= is_etx && pid_set;
            r_int_target <= (is_etx && pid_set) ? i_fg_pid[sc2a_pkg::TGT_W-1:0] : '0;
            r_ctrl_c     <= is_etx;
        end
    end

    assign o_out_valid        = r_out_valid;
    assign o_read_valid       = r_read_valid;
    assign o_read_char        = r_read_valid ? r_rd_q : '0;
    assign o_echo_valid       = r_echo_valid;
    assign o_echo_char        = r_echo_char;
    assign o_wake_reader      = r_wake;
    assign o_dropped          = r_dropped;
    assign o_interrupt_valid  = r_int_valid;
    assign o_interrupt_target = r_int_target;
    assign o_ctrl_c_seen      = r_ctrl_c;

endmodule

// ===== src/scancode_to_ascii_key_buffer.sv =====
// ----------------------------------------------------------------------------
// scancode_to_ascii_key_buffer: set-1 scancode translator with character ring
// Translates key presses into ASCII, tracks ctrl/shift, handles ctrl+c and
// serves single-character reads from a character ring.
//
//   channel | direction | handshake                | payload
//   --------+-----------+--------------------------+----------------------------
//   in      | input     | i_in_valid / o_in_stall  | i_operation, i_scan_byte
//   out     | output    | o_out_valid / i_out_stall| read, echo, wake, drop, irq
//   cfg     | input     | i_cfg_valid / o_cfg_ready| i_cfg_data (foreground pid)
//
// One item per cycle sustained while the output is not stalled. The edge that
// accepts an item writes its command into the command queue; the ring back end
// then executes the command from the queue head into the result register. The
// 4-entry command queue absorbs output stalls; the input stalls only when it is
// full. Reset clears the modifiers, queue, ring pointers and result valid; ring
// contents are not cleared.
// ----------------------------------------------------------------------------
module scancode_to_ascii_key_buffer #(
    parameter int RING_DEPTH = sc2a_pkg::RING_DEPTH_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_in_valid,
    output logic                         o_in_stall,
    input  logic                         i_operation,
    input  logic [sc2a_pkg::SCAN_W-1:0]  i_scan_byte,
    output logic                         o_out_valid,
    input  logic                         i_out_stall,
    output logic                         o_read_valid,
    output logic [sc2a_pkg::CHAR_W-1:0]  o_read_char,
    output logic                         o_echo_valid,
    output logic [sc2a_pkg::CHAR_W-1:0]  o_echo_char,
    output logic                         o_wake_reader,
    output logic                         o_dropped,
    output logic                         o_interrupt_valid,
    output logic [sc2a_pkg::TGT_W-1:0]   o_interrupt_target,
    output logic                         o_ctrl_c_seen,
    input  logic                         i_cfg_valid,
    output logic                         o_cfg_ready,
    input  logic [sc2a_pkg::PID_W-1:0]   i_cfg_data
);

    logic [sc2a_pkg::PID_W-1:0]  r_fg_pid;
    logic                        fifo_full;
    logic                        fifo_not_empty;
    logic                        front_push;
    logic                        back_pop;
    sc2a_pkg::t_cmd              front_cmd;
    sc2a_pkg::t_cmd              head_cmd;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fg_pid <= '1;   // none
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_fg_pid <= i_cfg_data;
        end
    end

    sc2a_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_in_valid),
        .i_operation (i_operation),
        .i_scan_byte (i_scan_byte),
        .i_full      (fifo_full),
        .o_stall     (o_in_stall),
        .o_push      (front_push),
        .o_cmd       (front_cmd)
    );

    sc2a_cmd_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (front_push),
        .i_cmd       (front_cmd),
        .i_pop       (back_pop),
        .o_full      (fifo_full),
        .o_not_empty (fifo_not_empty),
        .o_cmd       (head_cmd)
    );

    sc2a_ring #(
        .RING_DEPTH (RING_DEPTH)
    ) u_ring (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd_valid        (fifo_not_empty),
        .i_cmd              (head_cmd),
        .i_fg_pid           (r_fg_pid),
        .i_out_stall        (i_out_stall),
        .o_pop              (back_pop),
        .o_out_valid        (o_out_valid),
        .o_read_valid       (o_read_valid),
        .o_read_char        (o_read_char),
        .o_echo_valid       (o_echo_valid),
        .o_echo_char        (o_echo_char),
        .o_wake_reader      (o_wake_reader),
        .o_dropped          (o_dropped),
        .o_interrupt_valid  (o_interrupt_valid),
        .o_interrupt_target (o_interrupt_target),
        .o_ctrl_c_seen      (o_ctrl_c_seen)
    );

endmodule

// ===== src/sc2a_checker.sv =====
// ----------------------------------------------------------------------------
// sc2a_checker: port-level checks
// Watches the top-level ports for handshake and result consistency.
// ----------------------------------------------------------------------------
module sc2a_checker (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         o_out_valid,
    input  logic                         i_out_stall,
    input  logic                         o_read_valid,
    input  logic [sc2a_pkg::CHAR_W-1:0]  o_read_char,
    input  logic                         o_echo_valid,
    input  logic                         o_wake_reader,
    input  logic                         o_dropped,
    input  logic                         o_interrupt_valid,
    input  logic                         o_ctrl_c_seen
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_read_char)
            && $stable(o_read_valid) && $stable(o_wake_reader))
        else $error("stalled result changed");

    // a read result carries nothing from the key path
    a_read_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_read_valid |-> !o_wake_reader && !o_echo_valid && !o_ctrl_c_seen)
        else $error("read result mixed with key result");

    a_drop_wake: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_dropped |-> o_wake_reader)
        else $error("drop without push attempt");

    a_irq_ctrlc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_interrupt_valid |-> o_ctrl_c_seen && !o_echo_valid)
        else $error("interrupt without ctrl+c");

endmodule

bind scancode_to_ascii_key_buffer sc2a_checker u_sc2a_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .o_out_valid       (o_out_valid),
    .i_out_stall       (i_out_stall),
    .o_read_valid      (o_read_valid),
    .o_read_char       (o_read_char),
    .o_echo_valid      (o_echo_valid),
    .o_wake_reader     (o_wake_reader),
    .o_dropped         (o_dropped),
    .o_interrupt_valid (o_interrupt_valid),
    .o_ctrl_c_seen     (o_ctrl_c_seen)
);
